FILE: sv/wctm_pkg.sv
// Shared constants, codes and widths for the wall column texture mapper.
package wctm_pkg;

    // Default values for the top-level parameters.
    localparam int FRAC_BITS_DEF  = 16;
    localparam int COORD_BITS_DEF = 12;

    // Fixed field and state widths.
    localparam int FRAC_IN_W   = 16;
    localparam int LINE_H_W    = 16;
    localparam int TEX_COORD_W = 10;
    localparam int OFFSET_W    = 26;
    localparam int STEP_W      = 32;
    localparam int POS_W       = 48;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // Largest supported texture size, as log2.
    localparam logic [3:0] TEX_LOG2_MAX = 4'd10;

    // Request codes.
    localparam logic REQ_BEGIN = 1'b0;
    localparam logic REQ_ROW   = 1'b1;

    // Hit side codes.
    localparam logic SIDE_X = 1'b0;
    localparam logic SIDE_Y = 1'b1;

    // Ray direction sign codes.
    localparam logic [1:0] SIGN_NEG = 2'd0;
    localparam logic [1:0] SIGN_POS = 2'd2;

    // Texture identifiers.
    localparam logic [1:0] TEX_EAST  = 2'd0;
    localparam logic [1:0] TEX_WEST  = 2'd1;
    localparam logic [1:0] TEX_SOUTH = 2'd2;
    localparam logic [1:0] TEX_NORTH = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TEX_LOG2    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEXEL_BYTES = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_H    = 2'd3;

    // Configuration reset values.
    localparam logic [3:0]  TEX_LOG2_RST    = 4'd6;
    localparam logic [15:0] ROW_BYTES_RST   = 16'd256;
    localparam logic [3:0]  TEXEL_BYTES_RST = 4'd4;
    localparam logic [11:0] SCREEN_H_RST    = 12'd480;

endpackage

FILE: sv/wctm_if.sv
// Valid/ready channel interfaces for requests, results and configuration writes.
interface wctm_req_if #(
    parameter int COORD_BITS = wctm_pkg::COORD_BITS_DEF
);
    import wctm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  req_type;
    logic                  hit_side;
    logic [1:0]            dir_x_sign;
    logic [1:0]            dir_y_sign;
    logic [FRAC_IN_W-1:0]  wall_fraction;
    logic [LINE_H_W-1:0]   slice_height;
    logic [COORD_BITS-1:0] span_start;
    logic [COORD_BITS-1:0] span_end;
    logic [COORD_BITS-1:0] screen_column;

    modport source (
        output valid, req_type, hit_side, dir_x_sign, dir_y_sign, wall_fraction,
               slice_height, span_start, span_end, screen_column,
        input  ready
    );
    modport sink (
        input  valid, req_type, hit_side, dir_x_sign, dir_y_sign, wall_fraction,
               slice_height, span_start, span_end, screen_column,
        output ready
    );
endinterface

interface wctm_res_if #(
    parameter int COORD_BITS = wctm_pkg::COORD_BITS_DEF
);
    import wctm_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [1:0]             texture_id;
    logic [TEX_COORD_W-1:0] texel_column;
    logic [TEX_COORD_W-1:0] texel_row;
    logic [COORD_BITS-1:0]  pixel_row;
    logic [COORD_BITS-1:0]  pixel_column;
    logic [OFFSET_W-1:0]    texel_offset;
    logic                   last;

    modport source (
        output valid, texture_id, texel_column, texel_row, pixel_row, pixel_column,
               texel_offset, last,
        input  ready
    );
    modport sink (
        input  valid, texture_id, texel_column, texel_row, pixel_row, pixel_column,
               texel_offset, last,
        output ready
    );
endinterface

interface wctm_cfg_if;
    import wctm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/wall_column_texture_mapper_unit.sv
// Wall column texture mapper: per-column setup with a shared divider, then one texel per row.
// A next-row beat yields its result in the output register in the cycle after acceptance.
// A begin-column beat keeps the block busy through its divide, saturate and multiply states:
// one quotient bit per cycle of the shared restoring divider, then a saturate and a multiply step.
// Row beats go in one per cycle when idle and the output register is free or being drained.
// Reset (i_rst_n low, synchronous) restores the register defaults and leaves no column active.
module wall_column_texture_mapper_unit #(
    parameter int FRAC_BITS  = wctm_pkg::FRAC_BITS_DEF,
    parameter int COORD_BITS = wctm_pkg::COORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wctm_req_if.sink    i_req,
    wctm_res_if.source  o_res,
    wctm_cfg_if.sink    i_cfg
);
    import wctm_pkg::*;

    // Dividend is texture size shifted up by the fraction bits.
    localparam int NUM_W  = int'(TEX_LOG2_MAX) + FRAC_BITS + 1;
    localparam int CNT_W  = $clog2(NUM_W + 1);
    localparam int Q_W    = (NUM_W > STEP_W) ? NUM_W : STEP_W;
    localparam int BASE_W = ((COORD_BITS > LINE_H_W) ? COORD_BITS : LINE_H_W) + 2;
    localparam int PROD_W = BASE_W + STEP_W + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SAT,
        ST_MUL
    } t_state;

    // Configuration registers.
    logic [3:0]  r_tex_log2;
    logic [15:0] r_row_bytes;
    logic [3:0]  r_texel_bytes;
    logic [11:0] r_screen_h;

    // Column state.
    t_state                   r_state;
    logic                     r_active;
    logic [1:0]               r_texture;
    logic [TEX_COORD_W-1:0]   r_col;
    logic [STEP_W-1:0]        r_step;
    logic [POS_W-1:0]         r_pos;
    logic [COORD_BITS-1:0]    r_row;
    logic [COORD_BITS-1:0]    r_stop;
    logic [COORD_BITS-1:0]    r_held_col;
    logic signed [BASE_W-1:0] r_base;

    // Divider state.
    logic [LINE_H_W-1:0] r_lh;
    logic [LINE_H_W-1:0] r_rem;
    logic [NUM_W-1:0]    r_dq;
    logic [CNT_W-1:0]    r_cnt;

    // Output register.
    logic                   r_out_valid;
    logic [1:0]             r_out_tex;
    logic [TEX_COORD_W-1:0] r_out_col;
    logic [TEX_COORD_W-1:0] r_out_trow;
    logic [COORD_BITS-1:0]  r_out_prow;
    logic [COORD_BITS-1:0]  r_out_pcol;
    logic [OFFSET_W-1:0]    r_out_off;
    logic                   r_out_last;

    logic [3:0]             w_lg;
    logic [TEX_COORD_W-1:0] w_mask;
    logic                   w_ready;
    logic                   w_acc;
    logic                   w_begin;
    logic                   w_row_req;
    logic                   w_row_fire;
    logic [1:0]             w_tex;
    logic                   w_mirror;
    logic [25:0]            w_col_full;
    logic [TEX_COORD_W-1:0] w_col_raw;
    logic [TEX_COORD_W-1:0] w_col;
    logic [LINE_H_W-1:0]    w_lh;
    logic [BASE_W-1:0]      w_base;
    logic [LINE_H_W:0]      w_rem_sh;
    logic                   w_ge;
    logic [LINE_H_W:0]      w_rem_nx;
    logic [Q_W-1:0]         w_quot;
    logic signed [PROD_W-1:0] w_prod;
    logic [TEX_COORD_W-1:0] w_trow;
    logic [COORD_BITS:0]    w_row_inc;
    logic                   w_last;
    logic [OFFSET_W-1:0]    w_off;

    // Configuration writes are always taken.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_log2    <= TEX_LOG2_RST;
            r_row_bytes   <= ROW_BYTES_RST;
            r_texel_bytes <= TEXEL_BYTES_RST;
            r_screen_h    <= SCREEN_H_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_TEX_LOG2:    r_tex_log2    <= i_cfg.data[3:0];
                REG_ROW_BYTES:   r_row_bytes   <= i_cfg.data[15:0];
                REG_TEXEL_BYTES: r_texel_bytes <= i_cfg.data[3:0];
                REG_SCREEN_H:    r_screen_h    <= i_cfg.data[11:0];
                default: ;
            endcase
        end
    end

    // Texture size clamp and row mask.
    assign w_lg   = (r_tex_log2 > TEX_LOG2_MAX) ? TEX_LOG2_MAX : r_tex_log2;
    assign w_mask = TEX_COORD_W'((11'd1 << w_lg) - 11'd1);

    // Handshake on the request channel.
    assign w_ready     = (r_state == ST_IDLE) && (!r_out_valid || o_res.ready);
    assign i_req.ready = w_ready;
    assign w_acc       = i_req.valid && w_ready;
    assign w_begin     = w_acc && (i_req.req_type == REQ_BEGIN);
    assign w_row_req   = w_acc && (i_req.req_type == REQ_ROW);
    assign w_row_fire  = w_row_req && r_active && (r_row < r_stop);

    // Texture choice and mirrored texture column.
    always_comb begin
        if (i_req.hit_side == SIDE_X) begin
            w_tex    = (i_req.dir_x_sign == SIGN_POS) ? TEX_EAST : TEX_WEST;
            w_mirror = (i_req.dir_x_sign == SIGN_POS);
        end else begin
            w_tex    = (i_req.dir_y_sign == SIGN_POS) ? TEX_SOUTH : TEX_NORTH;
            w_mirror = (i_req.dir_y_sign == SIGN_NEG);
        end
    end

    assign w_col_full = 26'(i_req.wall_fraction) << w_lg;
    assign w_col_raw  = w_col_full[25:16];
    assign w_col      = w_mirror ? (~w_col_raw & w_mask) : w_col_raw;

    // Zero height counts as one; start base may go negative.
    assign w_lh   = (i_req.slice_height == '0) ? LINE_H_W'(1) : i_req.slice_height;
    assign w_base = BASE_W'(i_req.span_start) - BASE_W'(r_screen_h[11:1])
                  + BASE_W'(w_lh[LINE_H_W-1:1]);

    // One restoring division step per cycle.
    assign w_rem_sh = {r_rem, r_dq[NUM_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_lh});
    assign w_rem_nx = w_ge ? (w_rem_sh - {1'b0, r_lh}) : w_rem_sh;
    assign w_quot   = Q_W'(r_dq);

    // Start position product, kept modulo the position width.
    assign w_prod = r_base * $signed({1'b0, r_step});

    // Row outputs.
    assign w_trow    = r_pos[FRAC_BITS +: TEX_COORD_W] & w_mask;
    assign w_row_inc = {1'b0, r_row} + (COORD_BITS + 1)'(1);
    assign w_last    = (w_row_inc >= {1'b0, r_stop});
    assign w_off     = OFFSET_W'(w_trow) * OFFSET_W'(r_row_bytes)
                     + OFFSET_W'(r_col) * OFFSET_W'(r_texel_bytes);

    // Sequencer, column state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
            r_texture   <= TEX_EAST;
            r_col       <= '0;
            r_step      <= '0;
            r_pos       <= '0;
            r_row       <= '0;
            r_stop      <= '0;
            r_held_col  <= '0;
        end else begin
            // A new texel fills the output register; otherwise a taken beat empties it.
            if (w_row_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_begin) begin
                        r_texture  <= w_tex;
                        r_col      <= w_col;
                        r_row      <= i_req.span_start;
                        r_stop     <= i_req.span_end;
                        r_held_col <= i_req.screen_column;
                        r_active   <= (i_req.span_start < i_req.span_end);
                        r_base     <= $signed(w_base);
                        r_lh       <= w_lh;
                        r_rem      <= '0;
                        r_dq       <= NUM_W'(1) << (CNT_W'(w_lg) + CNT_W'(FRAC_BITS));
                        r_cnt      <= CNT_W'(NUM_W);
                        r_state    <= ST_DIV;
                    end else if (w_row_fire) begin
                        r_out_tex   <= r_texture;
                        r_out_col   <= r_col;
                        r_out_trow  <= w_trow;
                        r_out_prow  <= r_row;
                        r_out_pcol  <= r_held_col;
                        r_out_off   <= w_off;
                        r_out_last  <= w_last;
                        r_pos       <= r_pos + POS_W'(r_step);
                        r_row       <= w_row_inc[COORD_BITS-1:0];
                        if (w_last) begin
                            r_active <= 1'b0;
                        end
                    end else if (w_row_req) begin
                        r_active <= 1'b0;
                    end
                end
                ST_DIV: begin
                    r_rem <= w_rem_nx[LINE_H_W-1:0];
                    r_dq  <= {r_dq[NUM_W-2:0], w_ge};
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= ST_SAT;
                    end
                end
                ST_SAT: begin
                    // Step saturates at the largest 32-bit value.
                    if (w_quot > Q_W'(33'h0_FFFF_FFFF)) begin
                        r_step <= '1;
                    end else begin
                        r_step <= w_quot[STEP_W-1:0];
                    end
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_pos   <= w_prod[POS_W-1:0];
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Result channel.
    assign o_res.valid        = r_out_valid;
    assign o_res.texture_id   = r_out_tex;
    assign o_res.texel_column = r_out_col;
    assign o_res.texel_row    = r_out_trow;
    assign o_res.pixel_row    = r_out_prow;
    assign o_res.pixel_column = r_out_pcol;
    assign o_res.texel_offset = r_out_off;
    assign o_res.last         = r_out_last;

endmodule

FILE: bench/tb_top.sv
// Testbench for the wall column texture mapper: directed rows, random columns and a scoreboard.
module tb_top;
    import wctm_pkg::*;

    localparam int CW          = COORD_BITS_DEF;
    localparam int LIMIT       = 400000;
    localparam int SETTLE      = FRAC_BITS_DEF + 24;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 300;
    localparam int MAX_REPORTS = 10;

    // Sign codes the package leaves unnamed.
    localparam logic [1:0] SIGN_ZERO = 2'd1;
    localparam logic [1:0] SIGN_BAD  = 2'd3;

    typedef struct packed {
        logic          req_type;
        logic          hit_side;
        logic [1:0]    dir_x_sign;
        logic [1:0]    dir_y_sign;
        logic [15:0]   wall_fraction;
        logic [15:0]   slice_height;
        logic [CW-1:0] span_start;
        logic [CW-1:0] span_end;
        logic [CW-1:0] screen_column;
    } req_t;

    typedef struct packed {
        logic [1:0]             texture_id;
        logic [TEX_COORD_W-1:0] texel_column;
        logic [TEX_COORD_W-1:0] texel_row;
        logic [CW-1:0]          pixel_row;
        logic [CW-1:0]          pixel_column;
        logic [OFFSET_W-1:0]    texel_offset;
        logic                   last;
    } res_t;

    // What the sender knows about a beat: a hand-written expectation or none.
    typedef struct packed {
        logic typed;
        logic has;
        res_t res;
    } note_t;

    typedef struct packed {
        logic typed;
        logic has;
        req_t req;
        res_t res;
    } dir_row_t;

    localparam req_t ROW_BEAT = '{REQ_ROW, SIDE_X, SIGN_NEG, SIGN_NEG,
                                  16'd0, 16'd0, 12'd0, 12'd0, 12'd0};
    localparam req_t ROW_JUNK = '{REQ_ROW, SIDE_Y, SIGN_BAD, SIGN_BAD,
                                  16'hFFFF, 16'hFFFF, 12'hFFF, 12'hFFF, 12'hFFF};
    localparam res_t NO_TEXEL = '0;

    localparam int DIR_N = 23;

    // Directed stimulus; typed expectations come from the default register values.
    dir_row_t dir_rows [DIR_N] = '{
        // Row beat with no column open after reset.
        '{1'b1, 1'b0, ROW_BEAT, NO_TEXEL},
        // East wall, mirrored column, slice exactly screen high.
        '{1'b1, 1'b0, '{REQ_BEGIN, SIDE_X, SIGN_POS, SIGN_NEG,
                        16'd0, 16'd480, 12'd0, 12'd2, 12'd5}, NO_TEXEL},
        '{1'b1, 1'b1, ROW_BEAT, '{TEX_EAST, 10'd63, 10'd0, 12'd0, 12'd5, 26'd252, 1'b0}},
        '{1'b1, 1'b1, ROW_JUNK, '{TEX_EAST, 10'd63, 10'd0, 12'd1, 12'd5, 26'd252, 1'b1}},
        '{1'b1, 1'b0, ROW_BEAT, NO_TEXEL},
        // North wall, full fraction mirrored down to column zero.
        '{1'b1, 1'b0, '{REQ_BEGIN, SIDE_Y, SIGN_ZERO, SIGN_NEG,
                        16'hFFFF, 16'd64, 12'd208, 12'd209, 12'd7}, NO_TEXEL},
        '{1'b1, 1'b1, ROW_BEAT, '{TEX_NORTH, 10'd0, 10'd0, 12'd208, 12'd7, 26'd0, 1'b1}},
        // Unused sign code, zero line height, span at the bottom edge.
        '{1'b1, 1'b0, '{REQ_BEGIN, SIDE_X, SIGN_BAD, SIGN_POS,
                        16'h8000, 16'd0, 12'd4094, 12'd4095, 12'd4095}, NO_TEXEL},
        '{1'b1, 1'b1, ROW_BEAT, '{TEX_WEST, 10'd32, 10'd0, 12'd4094, 12'd4095, 26'd128, 1'b1}},
        // South wall with a negative start position.
        '{1'b0, 1'b0, '{REQ_BEGIN, SIDE_Y, SIGN_NEG, SIGN_POS,
                        16'd1, 16'd2, 12'd0, 12'd3, 12'd0}, NO_TEXEL},
        '{1'b0, 1'b0, ROW_BEAT, NO_TEXEL},
        '{1'b0, 1'b0, ROW_JUNK, NO_TEXEL},
        // A new column replaces the one still open; tallest slice.
        '{1'b0, 1'b0, '{REQ_BEGIN, SIDE_Y, SIGN_POS, SIGN_ZERO,
                        16'hFFFF, 16'hFFFF, 12'd100, 12'd4095, 12'd2048}, NO_TEXEL},
        '{1'b0, 1'b0, ROW_BEAT, NO_TEXEL},
        '{1'b0, 1'b0, ROW_BEAT, NO_TEXEL},
        // Empty span with start equal to end.
        '{1'b1, 1'b0, '{REQ_BEGIN, SIDE_X, SIGN_NEG, SIGN_BAD,
                        16'd12345, 16'd300, 12'd50, 12'd50, 12'd1}, NO_TEXEL},
        '{1'b1, 1'b0, ROW_JUNK, NO_TEXEL},
        // Empty span with start past end.
        '{1'b1, 1'b0, '{REQ_BEGIN, SIDE_X, SIGN_NEG, SIGN_NEG,
                        16'hAAAA, 16'd1, 12'd4095, 12'd0, 12'hFFF}, NO_TEXEL},
        '{1'b1, 1'b0, ROW_BEAT, NO_TEXEL},
        // Unused y sign on a y wall, one-pixel slice, span over the full coordinate range.
        '{1'b0, 1'b0, '{REQ_BEGIN, SIDE_Y, SIGN_ZERO, SIGN_BAD,
                        16'h5555, 16'd1, 12'd0, 12'd4095, 12'hAAA}, NO_TEXEL},
        '{1'b0, 1'b0, ROW_BEAT, NO_TEXEL},
        '{1'b0, 1'b0, ROW_JUNK, NO_TEXEL},
        '{1'b0, 1'b0, ROW_BEAT, NO_TEXEL}
    };

    logic clk;
    logic rst_n;

    wctm_req_if #(.COORD_BITS(CW)) req_bus ();
    wctm_res_if #(.COORD_BITS(CW)) res_bus ();
    wctm_cfg_if                    cfg_bus ();

    wall_column_texture_mapper_unit #(
        .FRAC_BITS  (FRAC_BITS_DEF),
        .COORD_BITS (CW)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_bus),
        .o_res   (res_bus),
        .i_cfg   (cfg_bus)
    );

    // Register copies and column state of the texel predictor.
    logic [3:0]        reg_log2        = TEX_LOG2_RST;
    logic [15:0]       reg_row_bytes   = ROW_BYTES_RST;
    logic [3:0]        reg_texel_bytes = TEXEL_BYTES_RST;
    logic [CW-1:0]     reg_screen_h    = SCREEN_H_RST;
    logic              col_live        = 1'b0;
    logic [1:0]        col_tex         = '0;
    logic [9:0]        col_texel       = '0;
    logic [STEP_W-1:0] row_step        = '0;
    logic [POS_W-1:0]  tex_pos         = '0;
    logic [CW-1:0]     row_now         = '0;
    logic [CW-1:0]     row_stop        = '0;
    logic [CW-1:0]     col_screen      = '0;

    res_t  texel_exp_q [$];
    note_t req_note_q [$];

    int errors     = 0;
    int beats_in   = 0;
    int beats_out  = 0;
    int settings   = 1;
    bit calm       = 1'b0;
    bit hold_start = 1'b0;

    // Clock, period 10.
    initial clk = 1'b0;
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Texel predictor: one request beat in, at most one texel out.
    task automatic map_texel(input req_t r, output bit hit, output res_t t);
        logic [3:0]  lg;
        logic [63:0] size, col, lh, step, base, prod, trow, off;
        logic        is_last;
        begin
            lg   = (reg_log2 > TEX_LOG2_MAX) ? TEX_LOG2_MAX : reg_log2;
            size = 64'd1 << lg;
            hit  = 1'b0;
            t    = '0;
            if (r.req_type == REQ_BEGIN) begin
                if (r.hit_side == SIDE_X) begin
                    col_tex = (r.dir_x_sign == SIGN_POS) ? TEX_EAST : TEX_WEST;
                end else begin
                    col_tex = (r.dir_y_sign == SIGN_POS) ? TEX_SOUTH : TEX_NORTH;
                end
                col = (64'(r.wall_fraction) * size) >> 16;
                if ((r.hit_side == SIDE_X && r.dir_x_sign == SIGN_POS) ||
                    (r.hit_side == SIDE_Y && r.dir_y_sign == SIGN_NEG)) begin
                    col = size - col - 64'd1;
                end
                col_texel = col[9:0];
                // A zero height slice behaves as one pixel high.
                lh   = (r.slice_height == '0) ? 64'd1 : 64'(r.slice_height);
                step = (size << FRAC_BITS_DEF) / lh;
                if (step > 64'hFFFF_FFFF) begin
                    step = 64'hFFFF_FFFF;
                end
                row_step = step[STEP_W-1:0];
                // Start row relative to the centered slice; may wrap negative.
                base       = 64'(r.span_start) - 64'(reg_screen_h >> 1) + (lh >> 1);
                prod       = base * step;
                tex_pos    = prod[POS_W-1:0];
                row_now    = r.span_start;
                row_stop   = r.span_end;
                col_screen = r.screen_column;
                col_live   = (r.span_start < r.span_end);
            end else if (!col_live || row_now >= row_stop) begin
                col_live = 1'b0;
            end else begin
                trow    = (64'(tex_pos) >> FRAC_BITS_DEF) & (size - 64'd1);
                is_last = ((13'(row_now) + 13'd1) >= 13'(row_stop));
                off     = trow * 64'(reg_row_bytes) + 64'(col_texel) * 64'(reg_texel_bytes);
                t.texture_id   = col_tex;
                t.texel_column = col_texel;
                t.texel_row    = trow[9:0];
                t.pixel_row    = row_now;
                t.pixel_column = col_screen;
                t.texel_offset = off[OFFSET_W-1:0];
                t.last         = is_last;
                hit            = 1'b1;
                tex_pos        = tex_pos + POS_W'(row_step);
                row_now        = row_now + 1'b1;
                if (is_last) begin
                    col_live = 1'b0;
                end
            end
        end
    endtask

    task automatic show_texel(input string tag, input res_t r);
        $display("  %s: tex %0d col %0d row %0d at (%0d,%0d) offset %0d last %0d", tag,
                 r.texture_id, r.texel_column, r.texel_row, r.pixel_row, r.pixel_column,
                 r.texel_offset, r.last);
    endtask

    // Scoreboard: register writes, request beats and texel beats seen at each edge.
    always @(posedge clk) begin : scoreboard
        req_t  seen;
        res_t  want, got;
        note_t n;
        bit    hit;
        if (rst_n && cfg_bus.valid && cfg_bus.ready) begin
            case (cfg_bus.index)
                REG_TEX_LOG2:    reg_log2        = cfg_bus.data[3:0];
                REG_ROW_BYTES:   reg_row_bytes   = cfg_bus.data;
                REG_TEXEL_BYTES: reg_texel_bytes = cfg_bus.data[3:0];
                REG_SCREEN_H:    reg_screen_h    = cfg_bus.data[CW-1:0];
                default: ;
            endcase
        end
        if (rst_n && req_bus.valid && req_bus.ready) begin
            seen = '{req_bus.req_type, req_bus.hit_side, req_bus.dir_x_sign,
                     req_bus.dir_y_sign, req_bus.wall_fraction, req_bus.slice_height,
                     req_bus.span_start, req_bus.span_end, req_bus.screen_column};
            n = req_note_q.pop_front();
            map_texel(seen, hit, want);
            if (n.typed) begin
                hit  = n.has;
                want = n.res;
            end
            if (hit) begin
                texel_exp_q.push_back(want);
            end
            beats_in++;
        end
        if (rst_n && res_bus.valid && res_bus.ready) begin
            got = '{res_bus.texture_id, res_bus.texel_column, res_bus.texel_row,
                    res_bus.pixel_row, res_bus.pixel_column, res_bus.texel_offset,
                    res_bus.last};
            beats_out++;
            if (texel_exp_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("unexpected texel beat");
                    show_texel("actual", got);
                end
            end else begin
                want = texel_exp_q.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= MAX_REPORTS) begin
                        $display("texel beat mismatch");
                        show_texel("expected", want);
                        show_texel("actual", got);
                    end
                end
            end
        end
    end

    // Result side: random stalls, one long hold-off on request, none while calm.
    initial begin : pixel_sink
        int hold_left;
        hold_left = 0;
        res_bus.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_start) begin
                hold_start = 1'b0;
                hold_left  = HOLD_CYCLES;
            end
            if (!rst_n) begin
                res_bus.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                res_bus.ready <= 1'b0;
            end else if (calm) begin
                res_bus.ready <= 1'b1;
            end else begin
                res_bus.ready <= ($urandom_range(99) >= 36);
            end
        end
    end

    // Cycle limit.
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    // Offer one request beat, after random idle cycles (none while calm), and wait for it to be taken.
    task automatic push_req(input req_t r, input bit typed, input bit has, input res_t want);
        note_t n;
        n.typed = typed;
        n.has   = has;
        n.res   = want;
        req_note_q.push_back(n);
        while (!calm && $urandom_range(99) < 36) begin
            req_bus.valid <= 1'b0;
            @(posedge clk);
        end
        req_bus.valid         <= 1'b1;
        req_bus.req_type      <= r.req_type;
        req_bus.hit_side      <= r.hit_side;
        req_bus.dir_x_sign    <= r.dir_x_sign;
        req_bus.dir_y_sign    <= r.dir_y_sign;
        req_bus.wall_fraction <= r.wall_fraction;
        req_bus.slice_height  <= r.slice_height;
        req_bus.span_start    <= r.span_start;
        req_bus.span_end      <= r.span_end;
        req_bus.screen_column <= r.screen_column;
        do @(posedge clk); while (!req_bus.ready);
    endtask

    // Write one register; the caller lowers valid after its last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do @(posedge clk); while (!cfg_bus.ready);
    endtask

    // Wait until every expected texel has come, then let a column setup finish.
    task automatic wait_idle();
        while (texel_exp_q.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    // Begin-column beat; a negative length gives random span bounds.
    function automatic req_t random_column(input int len);
        req_t r;
        int   lo;
        r               = '0;
        r.req_type      = REQ_BEGIN;
        r.hit_side      = 1'($urandom_range(1));
        r.dir_x_sign    = 2'($urandom_range(3));
        r.dir_y_sign    = 2'($urandom_range(3));
        r.screen_column = CW'($urandom);
        case ($urandom_range(7))
            0:       r.wall_fraction = 16'h0000;
            1:       r.wall_fraction = 16'hFFFF;
            default: r.wall_fraction = 16'($urandom);
        endcase
        case ($urandom_range(9))
            0:          r.slice_height = 16'd0;
            1:          r.slice_height = 16'hFFFF;
            2, 3:       r.slice_height = 16'($urandom_range(1, 16));
            4, 5, 6:    r.slice_height = 16'($urandom_range(17, 1023));
            default:    r.slice_height = 16'($urandom);
        endcase
        if (len < 0) begin
            r.span_start = CW'($urandom);
            r.span_end   = CW'($urandom);
        end else begin
            lo           = $urandom_range(4095 - len);
            r.span_start = CW'(lo);
            r.span_end   = CW'(lo + len);
        end
        return r;
    endfunction

    // Next-row beat with random contents in the ignored fields.
    function automatic req_t random_row();
        logic [95:0] junk;
        req_t        r;
        junk       = {$urandom, $urandom, $urandom};
        r          = req_t'(junk[$bits(req_t)-1:0]);
        r.req_type = REQ_ROW;
        return r;
    endfunction

    // Mostly whole columns with random contents, plus noise columns and stray rows.
    task automatic run_random_phase(input int quota);
        int   counted, len, rows, span, pick;
        bit   fresh;
        req_t c;
        counted = 0;
        while (counted < quota) begin
            pick  = $urandom_range(99);
            fresh = 1'b1;
            if (pick < 85) begin
                pick = $urandom_range(99);
                len  = (pick < 80) ? $urandom_range(1, 12) :
                       (pick < 95) ? $urandom_range(13, 64) : $urandom_range(65, 400);
                c    = random_column(len);
                span = len;
                pick = $urandom_range(99);
                // Cut short so the next column replaces this one, or run past the end.
                rows = (pick < 15) ? $urandom_range(0, len - 1) :
                       (pick < 30) ? len + $urandom_range(1, 3) : len;
            end else if (pick < 93) begin
                c    = random_column(-1);
                span = (c.span_end > c.span_start) ?
                       int'(c.span_end) - int'(c.span_start) : 0;
                rows = $urandom_range(0, 4);
            end else begin
                fresh = 1'b0;
                span  = 0;
                rows  = $urandom_range(1, 3);
            end
            if (fresh) begin
                push_req(c, 1'b0, 1'b0, NO_TEXEL);
                counted++;
            end
            for (int k = 0; k < rows; k++) begin
                push_req(random_row(), 1'b0, 1'b0, NO_TEXEL);
                if (k < span) begin
                    counted++;
                end
            end
        end
        // Leave a column open so the next register writes land mid-column.
        push_req(random_column(40), 1'b0, 1'b0, NO_TEXEL);
        push_req(random_row(), 1'b0, 1'b0, NO_TEXEL);
        push_req(random_row(), 1'b0, 1'b0, NO_TEXEL);
    endtask

    // Main sequence: reset, directed rows, then random phases under several settings.
    initial begin : main_seq
        int lg, rb, tbytes, sh;
        rst_n                 <= 1'b0;
        req_bus.valid         <= 1'b0;
        req_bus.req_type      <= REQ_BEGIN;
        req_bus.hit_side      <= SIDE_X;
        req_bus.dir_x_sign    <= SIGN_NEG;
        req_bus.dir_y_sign    <= SIGN_NEG;
        req_bus.wall_fraction <= '0;
        req_bus.slice_height  <= '0;
        req_bus.span_start    <= '0;
        req_bus.span_end      <= '0;
        req_bus.screen_column <= '0;
        cfg_bus.valid         <= 1'b0;
        cfg_bus.index         <= REG_TEX_LOG2;
        cfg_bus.data          <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_N; i++) begin
            push_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].has, dir_rows[i].res);
        end
        req_bus.valid <= 1'b0;
        wait_idle();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    lg = 0;  rb = 1;     tbytes = 1; sh = 1;
                end
                1: begin
                    lg = 10; rb = 65535; tbytes = 8; sh = 4095;
                end
                2: begin
                    // Size code past the largest texture.
                    lg = 15;
                    rb = $urandom_range(1, 65535);
                    tbytes = $urandom_range(1, 8);
                    sh = $urandom_range(1, 4095);
                end
                default: begin
                    lg = $urandom_range(12);
                    rb = $urandom_range(1, 65535);
                    tbytes = $urandom_range(1, 8);
                    sh = $urandom_range(1, 4095);
                end
            endcase
            write_reg(REG_TEX_LOG2, 16'(lg));
            write_reg(REG_ROW_BYTES, 16'(rb));
            write_reg(REG_TEXEL_BYTES, 16'(tbytes));
            write_reg(REG_SCREEN_H, 16'(sh));
            cfg_bus.valid <= 1'b0;
            settings++;
            calm = (p == 3);
            if (p == 1) begin
                hold_start = 1'b1;
            end
            run_random_phase(PHASE_ITEMS);
            req_bus.valid <= 1'b0;
            wait_idle();
        end
        calm = 1'b0;

        $display("Run covered %0d request beats and %0d texel beats over %0d register settings,",
                 beats_in, beats_out, settings);
        $display("with a %0d-cycle output hold-off and a stretch free of idle cycles.",
                 HOLD_CYCLES);
        if (errors == 0 && texel_exp_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

FILE: wall_column_texture_mapper_unit.f
sv/wctm_pkg.sv
sv/wctm_if.sv
sv/wall_column_texture_mapper_unit.sv
bench/tb_top.sv
